// File: rtl/hlt_pkg.sv
// ----------------------------------------------------------------------------
// hlt_pkg: shared definitions for the heartbeat liveness table
// Table geometry, status and command codes, register map, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int OWNER_W   = 32;
    localparam int TIME_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int EIDX_W    = 4;
    localparam int FREED_W   = 5;
    localparam int ENTRIES_W = 5;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;

    localparam logic [TIME_W-1:0]    TIMEOUT_RESET = 64'd1_000_000_000;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd16;
    localparam int                   FREED_MAX     = 31;

    // Register select is address bit 3: registers sit 8 bytes apart.
    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_TIMEOUT_NS     = 1'b1;

    localparam logic CMD_HEARTBEAT = 1'b0;
    localparam logic CMD_SWEEP     = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_REFRESHED  = 3'd0,
        STATUS_REGISTERED = 3'd1,
        STATUS_FULL       = 3'd2,
        STATUS_SWEPT      = 3'd3,
        STATUS_ZERO_ID    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] clamp_entries(input logic [ENTRIES_W-1:0] e);
        if (int'(e) > TABLE_ENTRIES) begin
            return CNT_W'(TABLE_ENTRIES);
        end
        return CNT_W'(e);
    endfunction

    function automatic logic [FREED_W-1:0] sat_freed(input logic [CNT_W-1:0] v);
        if (int'(v) > FREED_MAX) begin
            return FREED_W'(FREED_MAX);
        end
        return FREED_W'(v);
    endfunction

endpackage

// File: rtl/hlt_if.sv
// ----------------------------------------------------------------------------
// hlt_if: item channels of the heartbeat liveness table
// hlt_in_if carries request items, hlt_out_if carries result items, both
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hlt_in_if;
    import hlt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [OWNER_W-1:0]   owner_id;
    logic [TIME_W-1:0]    now_time;

    modport source (output valid, output cmd, output owner_id, output now_time,
                    input ready);
    modport sink   (input valid, input cmd, input owner_id, input now_time,
                    output ready);
endinterface

interface hlt_out_if;
    import hlt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [EIDX_W-1:0]    entry_index;
    logic [FREED_W-1:0]   freed_count;

    modport source (output valid, output status, output entry_index,
                    output freed_count, input ready);
    modport sink   (input valid, input status, input entry_index,
                    input freed_count, output ready);
endinterface

// File: rtl/hlt_ctrl.sv
// ----------------------------------------------------------------------------
// hlt_ctrl: sequencing controller
// Takes one item, steps the datapath across the active entries, then
// commits the result (and a heartbeat's table update) once the output register is free.
// ----------------------------------------------------------------------------
module hlt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hlt_pkg::dp_status_t dp_status,
    output hlt_pkg::dp_cmd_t    dp_cmd
);
    import hlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        dp_cmd     = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dp_status.scan_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    dp_cmd.step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_step_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.step |-> state_reg == S_SCAN && !dp_status.scan_done)
        else $error("scan step issued outside an unfinished scan");
    a_commit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> in_ready)
        else $error("controller did not return to idle after commit");
    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |=> state_reg == S_SCAN)
        else $error("accepted item did not start a scan");
`endif

endmodule

// File: rtl/hlt_datapath.sv
// ----------------------------------------------------------------------------
// hlt_datapath: entry store, scan logic and result register
// Holds the owner and last-seen stores, examines one entry per step and
// records the first match, the first free entry and the number freed.
// ----------------------------------------------------------------------------
module hlt_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hlt_pkg::dp_cmd_t                  dp_cmd,
    output hlt_pkg::dp_status_t               dp_status,
    input  logic                              in_cmd,
    input  logic [hlt_pkg::OWNER_W-1:0]       in_owner_id,
    input  logic [hlt_pkg::TIME_W-1:0]        in_now_time,
    input  logic [hlt_pkg::CNT_W-1:0]         active_n,
    input  logic [hlt_pkg::TIME_W-1:0]        timeout_ns,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [hlt_pkg::STATUS_W-1:0]      out_status,
    output logic [hlt_pkg::EIDX_W-1:0]        out_entry_index,
    output logic [hlt_pkg::FREED_W-1:0]       out_freed_count
);
    import hlt_pkg::*;

    logic [OWNER_W-1:0] owner_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0]  last_seen_mem [TABLE_ENTRIES];

    logic               cmd_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [CNT_W-1:0]   freed_reg;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [EIDX_W-1:0]  entry_idx_reg;
    logic [FREED_W-1:0] freed_count_reg;

    logic [IDX_W-1:0]   cur_idx;
    logic [OWNER_W-1:0] entry_owner;
    logic [TIME_W-1:0]  entry_age;
    logic               is_heartbeat;
    logic               zero_owner;
    logic               in_range;
    logic               is_match;
    logic               is_free;
    logic               is_stale;
    logic               do_register;
    logic               do_touch;
    logic [IDX_W-1:0]   touch_idx;
    status_t            status_next;
    logic [EIDX_W-1:0]  entry_idx_next;

    assign cur_idx      = idx_reg[IDX_W-1:0];
    assign entry_owner  = owner_mem[cur_idx];
    assign entry_age    = now_reg - last_seen_mem[cur_idx];
    assign is_heartbeat = (cmd_reg == CMD_HEARTBEAT);
    assign zero_owner   = (owner_reg == '0);
    assign in_range     = (idx_reg < active_n);
    assign is_match     = (entry_owner == owner_reg);
    assign is_free      = (entry_owner == '0);
    assign is_stale     = !is_free && (entry_age > timeout_ns);

    assign dp_status.scan_done = !in_range || (is_heartbeat && zero_owner);
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    // A refresh wins over a registration; both need a nonzero owner.
    assign do_touch    = dp_cmd.commit && is_heartbeat && !zero_owner
                         && (hit_reg || free_reg);
    assign do_register = do_touch && !hit_reg;
    assign touch_idx   = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        entry_idx_next = '0;
        if (!is_heartbeat)
        begin
            status_next = STATUS_SWEPT;
        end
        else if (zero_owner)
        begin
            status_next = STATUS_ZERO_ID;
        end
        else if (hit_reg)
        begin
            status_next    = STATUS_REFRESHED;
            entry_idx_next = EIDX_W'(hit_idx_reg);
        end
        else if (free_reg)
        begin
            status_next    = STATUS_REGISTERED;
            entry_idx_next = EIDX_W'(free_idx_reg);
        end
        else
        begin
            status_next = STATUS_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                owner_mem[i] <= '0;
            end
        end
        else if (dp_cmd.step && !is_heartbeat && is_stale)
        begin
            owner_mem[cur_idx] <= '0;
        end
        else if (do_register)
        begin
            owner_mem[free_idx_reg] <= owner_reg;
        end
    end

    // Timestamps are only read for occupied entries, and every entry that
    // becomes occupied gets its timestamp written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (do_touch)
        begin
            last_seen_mem[touch_idx] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= in_cmd;
            owner_reg <= in_owner_id;
            now_reg   <= in_now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            freed_reg    <= '0;
        end
        else if (dp_cmd.load)
        begin
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            freed_reg <= '0;
        end
        else if (dp_cmd.step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (is_heartbeat)
            begin
                if (is_match && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cur_idx;
                end
                if (is_free && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cur_idx;
                end
            end
            else if (is_stale)
            begin
                freed_reg <= freed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
        begin
            status_reg      <= status_next;
            entry_idx_reg   <= entry_idx_next;
            freed_count_reg <= is_heartbeat ? '0 : sat_freed(freed_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_entry_index = entry_idx_reg;
    assign out_freed_count = freed_count_reg;

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("pending result overwritten");
    a_freed_within_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.commit && !is_heartbeat) |-> freed_reg <= active_n)
        else $error("sweep freed more entries than are active");
    a_hit_within_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.commit && hit_reg) |-> CNT_W'(hit_idx_reg) < active_n)
        else $error("refreshed entry outside the active range");
    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> out_valid_reg)
        else $error("commit did not present a result");
`endif

endmodule

// File: rtl/heartbeat_liveness_table.sv
// Sequencing: an accepted item is scanned over N entries, where N is the
// active entry count (entries_in_use capped at the table size), one entry
// per cycle; a zero-identifier heartbeat skips the scan. The result is
// registered once the output register is free; a new item is taken after.
// Reset: asynchronous, active low; clears all owners and restores the
// register defaults. The block is ready for an item on the first cycle.
// ----------------------------------------------------------------------------
// heartbeat_liveness_table: owner liveness table with timeout sweep
// Heartbeats refresh or register owners; sweeps free stale entries. The
// configuration registers sit behind an APB-style port.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table (
    input  logic                        clk,
    input  logic                        rst_n,
    hlt_in_if.sink                      in_ch,
    hlt_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hlt_pkg::ADDR_W-1:0]  paddr,
    input  logic [hlt_pkg::DATA_W-1:0]  pwdata,
    output logic [hlt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import hlt_pkg::*;

    logic [ENTRIES_W-1:0] entries_reg;
    logic [TIME_W-1:0]    timeout_reg;
    logic                 cfg_write;
    logic                 reg_sel;
    dp_cmd_t              dp_cmd;
    dp_status_t           dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_ENTRIES_IN_USE: entries_reg <= pwdata[ENTRIES_W-1:0];
                REG_TIMEOUT_NS:     timeout_reg <= pwdata;
                default:            entries_reg <= entries_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ENTRIES_IN_USE: prdata = DATA_W'(entries_reg);
            REG_TIMEOUT_NS:     prdata = timeout_reg;
            default:            prdata = '0;
        endcase
    end

    hlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    hlt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .in_cmd          (in_ch.cmd),
        .in_owner_id     (in_ch.owner_id),
        .in_now_time     (in_ch.now_time),
        .active_n        (clamp_entries(entries_reg)),
        .timeout_ns      (timeout_reg),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_status      (out_ch.status),
        .out_entry_index (out_ch.entry_index),
        .out_freed_count (out_ch.freed_count)
    );

endmodule

// File: sim/hlt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlt_checker: result checker for the heartbeat liveness table
// Watches the request and result channels and the register port, keeps its
// own copy of the owner table and the registers, works out the result of
// every accepted request and compares it field by field with the result
// the block returns.
// ----------------------------------------------------------------------------
module hlt_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    hlt_in_if                          in_ch,
    hlt_out_if                         out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [hlt_pkg::ADDR_W-1:0] paddr,
    input  logic [hlt_pkg::DATA_W-1:0] pwdata,
    output int                         errors,
    output int                         outstanding,
    output int                         checked,
    output int                         refreshed,
    output int                         registered,
    output int                         dropped,
    output int                         freed_total
);
    import hlt_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [EIDX_W-1:0]   entry;
        logic [FREED_W-1:0]  freed;
    } outcome_t;

    logic [OWNER_W-1:0]   owner_tab [TABLE_ENTRIES];
    logic [TIME_W-1:0]    seen_tab  [TABLE_ENTRIES];
    logic [ENTRIES_W-1:0] entries_cfg;
    logic [TIME_W-1:0]    timeout_cfg;
    outcome_t             awaited_outcomes [$];

    // Applies one request to the local table and returns its outcome.
    function automatic outcome_t liveness_step(input logic op,
                                               input logic [OWNER_W-1:0] owner,
                                               input logic [TIME_W-1:0] now);
        outcome_t          res;
        int                span;
        int                slot;
        int                nfreed;
        logic [TIME_W-1:0] age;
        res.status = STATUS_SWEPT;
        res.entry  = '0;
        res.freed  = '0;
        span = (int'(entries_cfg) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_cfg);
        if (op == CMD_SWEEP)
        begin
            nfreed = 0;
            for (int i = 0; i < span; i++)
            begin
                age = now - seen_tab[i];
                if (owner_tab[i] != '0 && age > timeout_cfg)
                begin
                    owner_tab[i] = '0;
                    seen_tab[i]  = '0;
                    nfreed++;
                end
            end
            res.freed = (nfreed > FREED_MAX) ? FREED_W'(FREED_MAX) : FREED_W'(nfreed);
            return res;
        end
        if (owner == '0)
        begin
            res.status = STATUS_ZERO_ID;
            return res;
        end
        slot = -1;
        for (int i = 0; i < span; i++)
        begin
            if (slot < 0 && owner_tab[i] == owner)
            begin
                slot = i;
            end
        end
        if (slot >= 0)
        begin
            seen_tab[slot] = now;
            res.status = STATUS_REFRESHED;
            res.entry  = EIDX_W'(slot);
            return res;
        end
        for (int i = 0; i < span; i++)
        begin
            if (slot < 0 && owner_tab[i] == '0)
            begin
                slot = i;
            end
        end
        if (slot >= 0)
        begin
            owner_tab[slot] = owner;
            seen_tab[slot]  = now;
            res.status = STATUS_REGISTERED;
            res.entry  = EIDX_W'(slot);
            return res;
        end
        res.status = STATUS_FULL;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                owner_tab[i] = '0;
                seen_tab[i]  = '0;
            end
            entries_cfg = ENTRIES_RESET;
            timeout_cfg = TIMEOUT_RESET;
            awaited_outcomes.delete();
            errors      = 0;
            checked     = 0;
            refreshed   = 0;
            registered  = 0;
            dropped     = 0;
            freed_total = 0;
            outstanding <= 0;
        end
        else
        begin
            // Registers are only written while no item is in flight.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_TIMEOUT_NS)
                begin
                    timeout_cfg = pwdata[TIME_W-1:0];
                end
                else
                begin
                    entries_cfg = pwdata[ENTRIES_W-1:0];
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                awaited_outcomes.push_back(liveness_step(in_ch.cmd, in_ch.owner_id,
                                                         in_ch.now_time));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                checked++;
                if (awaited_outcomes.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t hlt_checker: result with no item pending", $time);
                    end
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (out_ch.status != want.status || out_ch.entry_index != want.entry
                        || out_ch.freed_count != want.freed)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t hlt_checker: result %0d mismatch: %s",
                                     $time, checked, "expected / got");
                            $display("    status %0d / %0d, index %0d / %0d, freed %0d / %0d",
                                     want.status, out_ch.status,
                                     want.entry, out_ch.entry_index,
                                     want.freed, out_ch.freed_count);
                        end
                    end
                    case (want.status)
                        STATUS_REFRESHED:  refreshed++;
                        STATUS_REGISTERED: registered++;
                        STATUS_FULL:       dropped++;
                        STATUS_SWEPT:      freed_total += int'(want.freed);
                        default: ;
                    endcase
                end
            end
            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the heartbeat liveness table
// Runs a directed opening and then random heartbeats and sweeps under
// several register settings, with bursty requests and a stalling result
// side; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import hlt_pkg::*;

    localparam int  HOLD_CYCLES  = 300;
    localparam int  SETTLE_CYCLES = 40;
    localparam real RUN_LIMIT_NS = 10_000_000.0;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int errors;
    int outstanding;
    int checked;
    int refreshed;
    int registered;
    int dropped;
    int freed_total;

    int          items_sent = 0;
    int          sweeps_sent = 0;
    int          reg_writes = 0;
    int          phases_run = 0;
    int          long_holds = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;
    logic [63:0] now_ns = 64'd0;

    hlt_in_if  in_ch ();
    hlt_out_if out_ch ();

    heartbeat_liveness_table u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hlt_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .refreshed   (refreshed),
        .registered  (registered),
        .dropped     (dropped),
        .freed_total (freed_total)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: mixes open stretches, random stalls and short blocks,
    // plus a long hold-off on request so that the block backs up.
    initial
    begin : result_stalls
        int mode;
        int len;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                long_holds++;
            end
            mode = $urandom_range(0, 9);
            len  = (mode >= 8) ? $urandom_range(1, 6) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
            begin
                if (mode < 5)
                    out_ch.ready <= 1'b1;
                else if (mode < 8)
                    out_ch.ready <= 1'($urandom_range(0, 1));
                else
                    out_ch.ready <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic op, input logic [OWNER_W-1:0] owner,
                             input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= op;
        in_ch.owner_id <= owner;
        in_ch.now_time <= now;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        if (op == CMD_SWEEP)
            sweeps_sent++;
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic reg_write(input logic sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // One register setting followed by random traffic. Owners come mostly
    // from a pool a little larger than the active range, so that refreshes,
    // new registrations and full-table drops all occur.
    task automatic run_phase(input logic [ENTRIES_W-1:0] entries,
                             input logic [TIME_W-1:0] tmo, input int unsigned tick_max,
                             input int jump_pct, input int count, input bit squeeze);
        logic [DATA_W-1:0]  wval;
        logic [OWNER_W-1:0] base;
        logic [OWNER_W-1:0] owner;
        logic               op;
        int                 span;
        int                 r;
        drain_results();
        wval = {$urandom, $urandom};
        wval[ENTRIES_W-1:0] = entries;
        reg_write(REG_ENTRIES_IN_USE, wval);
        reg_write(REG_TIMEOUT_NS, tmo);
        phases_run++;
        span = (int'(entries) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries);
        base = $urandom_range(1, 32'hFFFF_0000);
        if (squeeze)
            hold_off_req = 1'b1;
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(0, 99) < 15) ? CMD_SWEEP : CMD_HEARTBEAT;
            r = $urandom_range(0, 99);
            if (r < 4)
                owner = '0;
            else if (r < 10)
                owner = $urandom;
            else if (r < 12)
                owner = '1;
            else
                owner = base + $urandom_range(0, span + 2);
            r = $urandom_range(0, 99);
            if (r < jump_pct)
                now_ns = {$urandom, $urandom};
            else if (r < jump_pct + 3)
                now_ns = now_ns - $urandom_range(0, 1000);
            else
                now_ns = now_ns + $urandom_range(0, tick_max);
            send_item(op, owner, now_ns);
        end
    endtask

    initial
    begin : stimulus
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_HEARTBEAT;
        in_ch.owner_id = '0;
        in_ch.now_time = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset settings.
        send_item(CMD_HEARTBEAT, 32'd0, 64'd50);
        send_item(CMD_HEARTBEAT, 32'd1, 64'd100);
        send_item(CMD_HEARTBEAT, 32'hFFFF_FFFF, 64'd200);
        send_item(CMD_HEARTBEAT, 32'd1, 64'd300);
        send_item(CMD_SWEEP, 32'hFFFF_FFFF, 64'd500);
        send_item(CMD_SWEEP, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_SWEEP, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int k = 0; k < TABLE_ENTRIES; k++)
            send_item(CMD_HEARTBEAT, 32'd100 + k, 64'd1000);
        send_item(CMD_HEARTBEAT, 32'd200, 64'd2000);
        send_item(CMD_SWEEP, 32'd0, 64'd1000 + TIMEOUT_RESET + 64'd1);
        now_ns = 64'd1000 + TIMEOUT_RESET + 64'd1;

        run_phase(5'd16, 64'd5000, 2000, 1, 200, 1'b1);
        run_phase(5'd3, 64'd5000, 2000, 1, 150, 1'b0);
        run_phase(5'd0, 64'd0, 3, 1, 60, 1'b0);
        run_phase(5'd31, 64'd0, 3, 1, 150, 1'b0);
        run_phase(5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5, 100, 1'b0);
        run_phase(5'd16, 64'h8000_0000_0000_0000, 1000, 50, 100, 1'b0);
        run_phase(5'd1, TIMEOUT_RESET, 400_000_000, 1, 100, 1'b0);
        run_phase(5'd20, 64'd300, 100, 1, 200, 1'b1);
        run_phase(5'd9, 64'($urandom_range(50, 5000)), 1500, 1, 150, 1'b0);
        run_phase(5'd16, 64'd1_000_000, 400_000, 1, 200, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_top: %0d items (%0d sweeps), %0d settings, %0d register writes",
                 items_sent, sweeps_sent, phases_run, reg_writes);
        $display("tb_top: %0d long result stalls, %0d results checked (%0d %s %0d %s)",
                 long_holds, checked, refreshed, "refreshed,", registered,
                 "registered");
        $display("tb_top: %0d heartbeats dropped, %0d entries freed by sweeps",
                 dropped, freed_total);
        if (errors == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
